[rtl/core/pmrm_pkg.sv]
// Shared types and constants of the prioritized mask rule matcher.
`timescale 1ns / 1ps
package pmrm_pkg;

    localparam int MAX_RESULTS = 32;
    localparam int RES_CNT_W   = 6;
    localparam int MASK_W      = 64;
    // One stored rule: type bit, in up, in down, out up, out down.
    localparam int RULE_W      = 1 + 4 * MASK_W;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_DEL   = 2'd1,
        KIND_MATCH = 2'd2,
        KIND_NOP   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_BAD_TYPE  = 3'd3,
        ST_BAD_IN    = 3'd4,
        ST_BAD_OUT   = 3'd5,
        ST_NOT_FOUND = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DEL_SCAN,
        S_DEL_FIN,
        S_M_RD,
        S_M_EV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic decode;
        logic del_step;
        logic del_fin;
        logic m_eval;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic  in_valid;
        t_kind kind;
        logic  empty;
        logic  k_last;
        logic  stall;
        logic  can_load;
    } t_stat;

endpackage

[rtl/core/pmrm_ifs.sv]
// Request and response channel interfaces of the rule matcher.
`timescale 1ns / 1ps
interface pmrm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  rule_type;
    logic [63:0] in_up_mask;
    logic [63:0] in_down_mask;
    logic [63:0] out_up_mask;
    logic [63:0] out_down_mask;
    logic [3:0]  prio_level;
    logic [7:0]  target_id;
    logic [63:0] match_mask;

    modport source (output valid, kind, rule_type, in_up_mask, in_down_mask, out_up_mask,
                    out_down_mask, prio_level, target_id, match_mask, input ready);
    modport sink (input valid, kind, rule_type, in_up_mask, in_down_mask, out_up_mask,
                  out_down_mask, prio_level, target_id, match_mask, output ready);
endinterface

interface pmrm_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        hit;
    logic [7:0]  result_id;
    logic [3:0]  result_prio;
    logic [63:0] result_up;
    logic [63:0] result_down;
    logic        last;

    modport source (output valid, status, hit, result_id, result_prio, result_up,
                    result_down, last, input ready);
    modport sink (input valid, status, hit, result_id, result_prio, result_up,
                  result_down, last, output ready);
endinterface

[rtl/core/pmrm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pmrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/pmrm_dp.sv]
// Datapath: rule order list, rule store, scan registers and result registers.
`timescale 1ns / 1ps
module pmrm_dp #(
    parameter int SLOT_COUNT      = 32,
    parameter int PRIORITY_LEVELS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pmrm_pkg::t_cmd i_cmd,
    output pmrm_pkg::t_stat o_stat,
    pmrm_req_if.sink      i_req,
    pmrm_rsp_if.source    o_rsp
);
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);

    // Latched request.
    pmrm_pkg::t_kind r_kind;
    logic [1:0]  r_type;
    logic [63:0] r_iu, r_idn, r_ou, r_od, r_mm;
    logic [3:0]  r_pr;
    logic [7:0]  r_tid;

    // Table bookkeeping; list entries are kept sorted by priority, then age.
    logic          r_used [SLOT_COUNT];
    logic [CW-1:0] r_count;
    logic [7:0]    r_idc;
    logic [SW-1:0] r_ent_slot [SLOT_COUNT];
    logic [3:0]    r_ent_prio [SLOT_COUNT];
    logic [SW-1:0] r_ent_age  [SLOT_COUNT];
    logic [7:0]    r_ent_id   [SLOT_COUNT];

    // Scan state.
    logic [SW-1:0]         r_k;
    logic                  r_found;
    logic [SW-1:0]         r_best;
    logic [63:0]           r_uni_up, r_uni_dn;
    logic [pmrm_pkg::RES_CNT_W-1:0] r_nres;

    // Held result and output register.
    logic                  r_pend_valid;
    pmrm_pkg::t_status     r_pend_status;
    logic                  r_pend_hit;
    logic [7:0]            r_pend_id;
    logic [3:0]            r_pend_prio;
    logic [63:0]           r_pend_up, r_pend_dn;
    logic                  r_out_valid;
    pmrm_pkg::t_status     r_out_status;
    logic                  r_out_hit, r_out_last;
    logic [7:0]            r_out_id;
    logic [3:0]            r_out_prio;
    logic [63:0]           r_out_up, r_out_dn;

    logic                  accept;
    logic [pmrm_pkg::RULE_W-1:0] rd_data;
    logic                  rd_type;
    logic [63:0]           rd_iu, rd_idn, rd_ou, rd_od, cmp_up, cmp_dn;
    logic                  rule_hit, conflict, report, can_load, stall, k_last;
    logic [SW-1:0]         free_slot, ins_pos;
    logic [3:0]            pr_eff;
    pmrm_pkg::t_status     add_st;
    logic                  ram_we;
    logic [SW-1:0]         best_age;

    assign accept = i_req.valid && i_cmd.in_ready;
    assign i_req.ready = i_cmd.in_ready;

    pmrm_ram #(.WIDTH(pmrm_pkg::RULE_W), .DEPTH(SLOT_COUNT)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (free_slot),
        .i_wdata ({r_type[0], r_iu, r_idn, r_ou, r_od}),
        .i_raddr (r_ent_slot[r_k]),
        .o_rdata (rd_data)
    );

    assign rd_type = rd_data[4*64];
    assign rd_iu   = rd_data[4*64-1:3*64];
    assign rd_idn  = rd_data[3*64-1:2*64];
    assign rd_ou   = rd_data[2*64-1:64];
    assign rd_od   = rd_data[63:0];

    // Flex rules compare the whole word, fuzz rules only under their masks.
    always_comb begin
        cmp_up = rd_type ? (r_mm & rd_iu) : r_mm;
        cmp_dn = rd_type ? (~r_mm & rd_idn) : ~r_mm;
        rule_hit = !((rd_iu != '0 && cmp_up != rd_iu) || (rd_idn != '0 && cmp_dn != rd_idn));
    end

    assign conflict = (|(rd_ou & r_uni_dn)) || (|(rd_od & r_uni_up));
    assign report   = rule_hit && !conflict &&
                      (r_nres < pmrm_pkg::RES_CNT_W'(pmrm_pkg::MAX_RESULTS));
    assign can_load = !r_out_valid || o_rsp.ready;
    assign stall    = report && r_pend_valid && !can_load;
    assign k_last   = (CW'(r_k) + CW'(1)) == r_count;
    assign best_age = r_ent_age[r_best];

    always_comb begin
        free_slot = '0;
        ins_pos   = SW'(r_count);
        for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                free_slot = SW'(k);
            end
            if (CW'(k) < r_count && r_ent_prio[k] > pr_eff) begin
                ins_pos = SW'(k);
            end
        end
    end

    always_comb begin
        if (r_pr == 4'd0) begin
            pr_eff = 4'(PRIORITY_LEVELS - 1);
        end else if (r_pr > 4'(PRIORITY_LEVELS)) begin
            pr_eff = 4'(PRIORITY_LEVELS);
        end else begin
            pr_eff = r_pr;
        end
    end

    always_comb begin
        priority if (r_count >= CW'(SLOT_COUNT)) begin
            add_st = pmrm_pkg::ST_FULL;
        end else if (r_type > 2'd1) begin
            add_st = pmrm_pkg::ST_BAD_TYPE;
        end else if (|(r_iu & r_idn)) begin
            add_st = pmrm_pkg::ST_BAD_IN;
        end else if (|(r_ou & r_od)) begin
            add_st = pmrm_pkg::ST_BAD_OUT;
        end else begin
            add_st = pmrm_pkg::ST_OK;
        end
    end

    assign ram_we = i_cmd.decode && r_kind == pmrm_pkg::KIND_ADD && add_st == pmrm_pkg::ST_OK;

    always_comb begin
        o_stat.in_valid = i_req.valid;
        o_stat.kind     = r_kind;
        o_stat.empty    = r_count == '0;
        o_stat.k_last   = k_last;
        o_stat.stall    = stall;
        o_stat.can_load = can_load;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_idc        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int k = 0; k < SLOT_COUNT; k++) begin
                r_used[k] <= 1'b0;
            end
        end else begin
            if (ram_we) begin
                r_used[free_slot] <= 1'b1;
                r_count           <= r_count + CW'(1);
                r_idc             <= r_idc + 8'd1;
            end
            if (i_cmd.del_fin && r_found) begin
                r_used[r_ent_slot[r_best]] <= 1'b0;
                r_count                    <= r_count - CW'(1);
            end
            if (i_cmd.decode) begin
                r_pend_valid <= !((r_kind == pmrm_pkg::KIND_DEL ||
                                   r_kind == pmrm_pkg::KIND_MATCH) && r_count != '0);
            end else if (i_cmd.del_fin) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.m_eval && report && !stall) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.emit && can_load) begin
                r_pend_valid <= 1'b0;
            end
            if ((i_cmd.emit && can_load) ||
                (i_cmd.m_eval && report && r_pend_valid && can_load)) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and list registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= pmrm_pkg::t_kind'(i_req.kind);
            r_type <= i_req.rule_type;
            r_iu   <= i_req.in_up_mask;
            r_idn  <= i_req.in_down_mask;
            r_ou   <= i_req.out_up_mask;
            r_od   <= i_req.out_down_mask;
            r_pr   <= i_req.prio_level;
            r_tid  <= i_req.target_id;
            r_mm   <= i_req.match_mask;
        end

        if (i_cmd.decode) begin
            r_k      <= '0;
            r_found  <= 1'b0;
            r_uni_up <= '0;
            r_uni_dn <= '0;
            r_nres   <= '0;
            r_pend_hit  <= 1'b0;
            r_pend_up   <= '0;
            r_pend_dn   <= '0;
            unique case (r_kind)
                pmrm_pkg::KIND_ADD: begin
                    r_pend_status <= add_st;
                    r_pend_id     <= (add_st == pmrm_pkg::ST_OK) ? r_idc + 8'd1 : 8'd0;
                    r_pend_prio   <= (add_st == pmrm_pkg::ST_OK) ? pr_eff : 4'd0;
                end
                pmrm_pkg::KIND_DEL: begin
                    r_pend_status <= pmrm_pkg::ST_EMPTY;
                    r_pend_id     <= r_tid;
                    r_pend_prio   <= 4'd0;
                end
                pmrm_pkg::KIND_MATCH: begin
                    r_pend_status <= pmrm_pkg::ST_EMPTY;
                    r_pend_id     <= 8'd0;
                    r_pend_prio   <= 4'd0;
                end
                pmrm_pkg::KIND_NOP: begin
                    r_pend_status <= pmrm_pkg::ST_OK;
                    r_pend_id     <= 8'd0;
                    r_pend_prio   <= 4'd0;
                end
            endcase
        end

        // Insert the new rule behind every rule of the same or a lower level.
        if (ram_we) begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
                if (SW'(k) > ins_pos) begin
                    r_ent_slot[k] <= r_ent_slot[(k == 0) ? 0 : k - 1];
                    r_ent_prio[k] <= r_ent_prio[(k == 0) ? 0 : k - 1];
                    r_ent_age[k]  <= r_ent_age[(k == 0) ? 0 : k - 1];
                    r_ent_id[k]   <= r_ent_id[(k == 0) ? 0 : k - 1];
                end else if (SW'(k) == ins_pos) begin
                    r_ent_slot[k] <= free_slot;
                    r_ent_prio[k] <= pr_eff;
                    r_ent_age[k]  <= SW'(r_count);
                    r_ent_id[k]   <= r_idc + 8'd1;
                end
            end
        end

        // The oldest rule with the target id wins.
        if (i_cmd.del_step) begin
            if (r_ent_id[r_k] == r_tid && (!r_found || r_ent_age[r_k] < best_age)) begin
                r_found <= 1'b1;
                r_best  <= r_k;
            end
            r_k <= r_k + SW'(1);
        end

        if (i_cmd.del_fin) begin
            r_pend_id <= r_tid;
            if (r_found) begin
                r_pend_status <= pmrm_pkg::ST_OK;
                r_pend_prio   <= r_ent_prio[r_best];
                for (int k = 0; k < SLOT_COUNT; k++) begin
                    if (SW'(k) >= r_best) begin
                        r_ent_slot[k] <= r_ent_slot[(k == SLOT_COUNT - 1) ? k : k + 1];
                        r_ent_prio[k] <= r_ent_prio[(k == SLOT_COUNT - 1) ? k : k + 1];
                        r_ent_id[k]   <= r_ent_id[(k == SLOT_COUNT - 1) ? k : k + 1];
                        r_ent_age[k]  <= r_ent_age[(k == SLOT_COUNT - 1) ? k : k + 1] -
                            SW'(r_ent_age[(k == SLOT_COUNT - 1) ? k : k + 1] > best_age);
                    end else begin
                        r_ent_age[k] <= r_ent_age[k] - SW'(r_ent_age[k] > best_age);
                    end
                end
            end else begin
                r_pend_status <= pmrm_pkg::ST_NOT_FOUND;
            end
        end

        if (i_cmd.m_eval && !stall) begin
            r_k <= r_k + SW'(1);
            if (rule_hit && !conflict) begin
                r_uni_up <= r_uni_up | rd_ou;
                r_uni_dn <= r_uni_dn | rd_od;
            end
            if (report) begin
                r_nres        <= r_nres + pmrm_pkg::RES_CNT_W'(1);
                r_pend_status <= pmrm_pkg::ST_OK;
                r_pend_hit    <= 1'b1;
                r_pend_id     <= r_ent_id[r_k];
                r_pend_prio   <= r_ent_prio[r_k];
                r_pend_up     <= rd_ou;
                r_pend_dn     <= rd_od;
            end
        end

        if (i_cmd.m_eval && report && r_pend_valid && can_load) begin
            r_out_status <= r_pend_status;
            r_out_hit    <= r_pend_hit;
            r_out_id     <= r_pend_id;
            r_out_prio   <= r_pend_prio;
            r_out_up     <= r_pend_up;
            r_out_dn     <= r_pend_dn;
            r_out_last   <= 1'b0;
        end else if (i_cmd.emit && can_load) begin
            r_out_status <= r_pend_valid ? r_pend_status : pmrm_pkg::ST_OK;
            r_out_hit    <= r_pend_valid && r_pend_hit;
            r_out_id     <= r_pend_valid ? r_pend_id : 8'd0;
            r_out_prio   <= r_pend_valid ? r_pend_prio : 4'd0;
            r_out_up     <= r_pend_valid ? r_pend_up : 64'd0;
            r_out_dn     <= r_pend_valid ? r_pend_dn : 64'd0;
            r_out_last   <= 1'b1;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.result_id   = r_out_id;
    assign o_rsp.result_prio = r_out_prio;
    assign o_rsp.result_up   = r_out_up;
    assign o_rsp.result_down = r_out_dn;
    assign o_rsp.last        = r_out_last;
endmodule

[rtl/core/pmrm_ctrl.sv]
// Controller state machine that sequences decode, delete scan and match walk.
`timescale 1ns / 1ps
module pmrm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pmrm_pkg::t_stat i_stat,
    output pmrm_pkg::t_cmd  o_cmd
);
    pmrm_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pmrm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            pmrm_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    n_state = pmrm_pkg::S_DECODE;
                end
            end
            pmrm_pkg::S_DECODE: begin
                o_cmd.decode = 1'b1;
                if (i_stat.kind == pmrm_pkg::KIND_DEL && !i_stat.empty) begin
                    n_state = pmrm_pkg::S_DEL_SCAN;
                end else if (i_stat.kind == pmrm_pkg::KIND_MATCH && !i_stat.empty) begin
                    n_state = pmrm_pkg::S_M_RD;
                end else begin
                    n_state = pmrm_pkg::S_EMIT;
                end
            end
            pmrm_pkg::S_DEL_SCAN: begin
                o_cmd.del_step = 1'b1;
                if (i_stat.k_last) begin
                    n_state = pmrm_pkg::S_DEL_FIN;
                end
            end
            pmrm_pkg::S_DEL_FIN: begin
                o_cmd.del_fin = 1'b1;
                n_state       = pmrm_pkg::S_EMIT;
            end
            pmrm_pkg::S_M_RD: begin
                n_state = pmrm_pkg::S_M_EV;
            end
            pmrm_pkg::S_M_EV: begin
                o_cmd.m_eval = 1'b1;
                if (!i_stat.stall) begin
                    n_state = i_stat.k_last ? pmrm_pkg::S_EMIT : pmrm_pkg::S_M_RD;
                end
            end
            pmrm_pkg::S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_stat.can_load) begin
                    n_state = pmrm_pkg::S_IDLE;
                end
            end
            default: n_state = pmrm_pkg::S_IDLE;
        endcase
    end
endmodule

[rtl/core/prioritized_mask_rule_matcher.sv]
// Top level of the prioritized mask rule matcher.
//
//   Channel  Dir  Beat contents
//   i_req    in   kind, rule_type, in/out up/down masks, prio_level, target_id, match_mask
//   o_rsp    out  status, hit, result_id, result_prio, result_up, result_down, last
//
// One request is taken at a time. Add, a nop and requests on an empty table go
// from decode straight to their result beat; delete first scans the order list for
// the oldest rule with the target id, and match does one read and one evaluation of
// the rule RAM per stored rule. Reset is synchronous and clears the table at once. A
// stalled response channel holds the walk when a second result beat is ready, and
// holds the final beat of a request, and with it the input, until the output is free.
`timescale 1ns / 1ps
module prioritized_mask_rule_matcher #(
    parameter int SLOT_COUNT      = 32,
    parameter int PRIORITY_LEVELS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pmrm_req_if.sink   i_req,
    pmrm_rsp_if.source o_rsp
);
    // The controller only issues step commands; the datapath keeps the rules
    // sorted by level then age, so the match walk is a single linear pass.
    pmrm_pkg::t_cmd  cmd;
    pmrm_pkg::t_stat stat;

    pmrm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    pmrm_dp #(
        .SLOT_COUNT      (SLOT_COUNT),
        .PRIORITY_LEVELS (PRIORITY_LEVELS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );
endmodule

[tb/prioritized_mask_rule_matcher_test.sv]
// Self-checking testbench of the prioritized mask rule matcher.
`timescale 1ns / 1ps
module prioritized_mask_rule_matcher_test;

    localparam int CAP    = 32;
    localparam int LEVELS = 8;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  status;
        logic        hit;
        logic [7:0]  id;
        logic [3:0]  prio;
        logic [63:0] up;
        logic [63:0] down;
        logic        last;
    } t_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pmrm_req_if req_ch ();
    pmrm_rsp_if rsp_ch ();

    prioritized_mask_rule_matcher #(.SLOT_COUNT(CAP), .PRIORITY_LEVELS(LEVELS)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the rule table, kept in step with every accepted beat.
    logic        tbl_used [CAP];
    logic        tbl_fuzz [CAP];
    logic [63:0] tbl_iu [CAP], tbl_id [CAP], tbl_ou [CAP], tbl_od [CAP];
    logic [3:0]  tbl_prio [CAP];
    logic [7:0]  tbl_rid [CAP];
    int          tbl_rank [CAP];
    int          rules_held;
    logic [7:0]  last_id;

    t_beat expected_beats[$];
    int    errors = 0;
    int    n_req = 0, n_rsp = 0, n_hits = 0;
    int    idle_cycles = 0;
    bit    hold_off = 0;
    int    hold_cycles = 0;

    function automatic t_beat mk(pmrm_pkg::t_status st, logic [7:0] id, logic [3:0] pr,
                                 logic [63:0] up, logic [63:0] dn, logic hit,
                                 logic lst);
        t_beat b;
        b.status = st; b.hit = hit; b.id = id; b.prio = pr;
        b.up = up; b.down = dn; b.last = lst;
        return b;
    endfunction

    function automatic bit rule_fires(int s, logic [63:0] m);
        logic [63:0] up, dn;
        up = tbl_fuzz[s] ? (m & tbl_iu[s]) : m;
        dn = tbl_fuzz[s] ? (~m & tbl_id[s]) : ~m;
        if (tbl_iu[s] != 0 && up != tbl_iu[s]) return 0;
        if (tbl_id[s] != 0 && dn != tbl_id[s]) return 0;
        return 1;
    endfunction

    // Predicts the result beats of one request and updates the shadow table.
    task automatic predict_results(logic [1:0] kind, logic [1:0] rtype,
                                   logic [63:0] iu, logic [63:0] idn,
                                   logic [63:0] ou, logic [63:0] od,
                                   logic [3:0] pr, logic [7:0] tid, logic [63:0] m);
        int free_s, found, n, s, r;
        int by_rank [CAP];
        logic [63:0] uu, ud;
        logic [3:0] p;
        free_s = -1; found = -1; n = 0; uu = '0; ud = '0;
        case (pmrm_pkg::t_kind'(kind))
            pmrm_pkg::KIND_ADD: begin
                for (s = CAP - 1; s >= 0; s--) if (!tbl_used[s]) free_s = s;
                if (rules_held >= CAP || free_s < 0)
                    expected_beats.push_back(mk(pmrm_pkg::ST_FULL, 0, 0, 0, 0, 0, 1));
                else if (rtype > 1)
                    expected_beats.push_back(mk(pmrm_pkg::ST_BAD_TYPE, 0, 0, 0, 0, 0, 1));
                else if ((iu & idn) != 0)
                    expected_beats.push_back(mk(pmrm_pkg::ST_BAD_IN, 0, 0, 0, 0, 0, 1));
                else if ((ou & od) != 0)
                    expected_beats.push_back(mk(pmrm_pkg::ST_BAD_OUT, 0, 0, 0, 0, 0, 1));
                else begin
                    p = pr;
                    if (p == 0) p = 4'(LEVELS - 1);
                    if (p > 4'(LEVELS)) p = 4'(LEVELS);
                    last_id++;
                    tbl_used[free_s] = 1; tbl_fuzz[free_s] = rtype[0];
                    tbl_iu[free_s] = iu; tbl_id[free_s] = idn;
                    tbl_ou[free_s] = ou; tbl_od[free_s] = od;
                    tbl_prio[free_s] = p; tbl_rid[free_s] = last_id;
                    tbl_rank[free_s] = rules_held;
                    rules_held++;
                    expected_beats.push_back(mk(pmrm_pkg::ST_OK, last_id, p, 0, 0, 0, 1));
                end
            end
            pmrm_pkg::KIND_DEL: begin
                if (rules_held == 0) begin
                    expected_beats.push_back(mk(pmrm_pkg::ST_EMPTY, tid, 0, 0, 0, 0, 1));
                end else begin
                    for (s = 0; s < CAP; s++)
                        if (tbl_used[s] && tbl_rid[s] == tid &&
                            (found < 0 || tbl_rank[s] < tbl_rank[found])) found = s;
                    if (found < 0) begin
                        expected_beats.push_back(mk(pmrm_pkg::ST_NOT_FOUND, tid, 0, 0, 0, 0,
                                                    1));
                    end else begin
                        for (s = 0; s < CAP; s++)
                            if (tbl_used[s] && tbl_rank[s] > tbl_rank[found])
                                tbl_rank[s]--;
                        tbl_used[found] = 0;
                        rules_held--;
                        expected_beats.push_back(mk(pmrm_pkg::ST_OK, tid, tbl_prio[found],
                                                    0, 0, 0, 1));
                    end
                end
            end
            pmrm_pkg::KIND_MATCH: begin
                if (rules_held == 0) begin
                    expected_beats.push_back(mk(pmrm_pkg::ST_EMPTY, 0, 0, 0, 0, 0, 1));
                end else begin
                    for (r = 0; r < CAP; r++) by_rank[r] = -1;
                    for (s = 0; s < CAP; s++) if (tbl_used[s]) by_rank[tbl_rank[s]] = s;
                    for (int lv = 1; lv <= 15; lv++) begin
                        for (r = 0; r < CAP; r++) begin
                            s = by_rank[r];
                            if (s < 0 || tbl_prio[s] != lv) continue;
                            if (!rule_fires(s, m)) continue;
                            if ((tbl_ou[s] & ud) != 0 || (tbl_od[s] & uu) != 0) continue;
                            uu |= tbl_ou[s];
                            ud |= tbl_od[s];
                            if (n < pmrm_pkg::MAX_RESULTS) begin
                                expected_beats.push_back(mk(pmrm_pkg::ST_OK, tbl_rid[s],
                                                            tbl_prio[s], tbl_ou[s],
                                                            tbl_od[s], 1, 0));
                                n++;
                            end
                        end
                    end
                    if (n == 0) expected_beats.push_back(mk(pmrm_pkg::ST_OK, 0, 0, 0, 0, 0, 1));
                    else expected_beats[$].last = 1;
                end
            end
            default: expected_beats.push_back(mk(pmrm_pkg::ST_OK, 0, 0, 0, 0, 0, 1));
        endcase
    endtask

    task automatic report(string what, t_beat got, t_beat want);
        errors++;
        $display("ERROR %0t: %s got st=%0d hit=%0d id=%0d pr=%0d up=%h dn=%h last=%0d, ",
                 $time, what, got.status, got.hit, got.id, got.prio, got.up, got.down,
                 got.last,
                 "want st=%0d hit=%0d id=%0d pr=%0d up=%h dn=%h last=%0d",
                 want.status, want.hit, want.id, want.prio, want.up, want.down, want.last);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sends one request beat; the prediction is made when it is accepted.
    // The block takes a request only in its idle state, so valid always drops
    // for at least the cycle after an accept.
    task automatic send_req(logic [1:0] kind, logic [1:0] rtype = 0,
                            logic [63:0] iu = 0, logic [63:0] idn = 0,
                            logic [63:0] ou = 0, logic [63:0] od = 0,
                            logic [3:0] pr = 0, logic [7:0] tid = 0,
                            logic [63:0] m = 0, bit no_gap = 0);
        int g;
        g = no_gap ? 0 : gap_len();
        repeat ((g == 0) ? 1 : g) @(posedge i_clk);
        req_ch.valid <= 1'b1;
        req_ch.kind <= kind; req_ch.rule_type <= rtype;
        req_ch.in_up_mask <= iu; req_ch.in_down_mask <= idn;
        req_ch.out_up_mask <= ou; req_ch.out_down_mask <= od;
        req_ch.prio_level <= pr; req_ch.target_id <= tid; req_ch.match_mask <= m;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_results(kind, rtype, iu, idn, ou, od, pr, tid, m);
        n_req++;
        req_ch.valid <= 1'b0;
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    // Sparse random word, so that fuzz rules and out masks often fit together.
    function automatic logic [63:0] sparse64();
        return rnd64() & rnd64() & rnd64();
    endfunction

    task automatic wait_drained();
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Response side: random back-pressure plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_off) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) < 70);
        end
    end

    // Checker: compares each result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_beat got, want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = mk(pmrm_pkg::t_status'(rsp_ch.status), rsp_ch.result_id,
                     rsp_ch.result_prio, rsp_ch.result_up, rsp_ch.result_down, rsp_ch.hit,
                     rsp_ch.last);
            n_rsp++;
            if (got.hit) n_hits++;
            if (expected_beats.size() == 0) begin
                report("unexpected beat", got, got);
            end else begin
                want = expected_beats.pop_front();
                if (got !== want) report("beat differs", got, want);
            end
        end
    end

    // Watchdog on cycles where neither channel moves a beat.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d beats outstanding", expected_beats.size());
            $display("prioritized_mask_rule_matcher: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_empty_table();
        send_req(pmrm_pkg::KIND_MATCH, .m(64'hFFFF_FFFF_FFFF_FFFF));
        send_req(pmrm_pkg::KIND_DEL, .tid(8'hFF));
        send_req(pmrm_pkg::KIND_NOP);
    endtask

    task automatic test_add_checks();
        send_req(pmrm_pkg::KIND_ADD, .rtype(2));
        send_req(pmrm_pkg::KIND_ADD, .rtype(3));
        send_req(pmrm_pkg::KIND_ADD, .rtype(1), .iu(64'h1), .idn(64'h1));
        send_req(pmrm_pkg::KIND_ADD, .rtype(0), .ou(64'h8000_0000_0000_0000),
                 .od(64'hFFFF_FFFF_FFFF_FFFF));
        // Flex rule with all-zero in masks matches any word; level 0 defaults.
        send_req(pmrm_pkg::KIND_ADD, .rtype(0), .ou(64'h1), .pr(0));
        // Levels above the top one saturate.
        send_req(pmrm_pkg::KIND_ADD, .rtype(1), .iu(64'hFFFF_FFFF_FFFF_FFFF), .od(64'h2),
                 .pr(15));
        send_req(pmrm_pkg::KIND_ADD, .rtype(1), .idn(64'hFFFF_FFFF_FFFF_FFFF), .ou(64'h4),
                 .pr(1));
        send_req(pmrm_pkg::KIND_ADD, .rtype(0), .iu(64'h00FF), .idn(64'hFF00), .od(64'h1),
                 .pr(8));
        send_req(pmrm_pkg::KIND_MATCH, .m(64'hFFFF_FFFF_FFFF_FFFF));
        send_req(pmrm_pkg::KIND_MATCH, .m(64'h0));
        send_req(pmrm_pkg::KIND_MATCH, .m(64'h00FF));
        send_req(pmrm_pkg::KIND_DEL, .tid(8'd77));
        send_req(pmrm_pkg::KIND_DEL, .tid(8'd2));
        send_req(pmrm_pkg::KIND_MATCH, .m(64'hFFFF_FFFF_FFFF_FFFF));
        wait_drained();
    endtask

    // Fills the table, stalls the response channel long enough to back up input.
    task automatic test_full_and_stall();
        hold_off = 1;
        fork
            begin
                while (hold_cycles < 300) @(posedge i_clk);
                hold_off = 0;
            end
            begin
                while (rules_held < CAP)
                    send_req(pmrm_pkg::KIND_ADD, .rtype(1), .iu(64'h1 << rules_held),
                             .ou(64'h1 << rules_held), .pr(4'($urandom_range(0, 8))),
                             .no_gap(1));
                send_req(pmrm_pkg::KIND_ADD, .rtype(0), .no_gap(1));
                // Every rule fires: the table holds as many rules as the cap of results.
                send_req(pmrm_pkg::KIND_MATCH, .m(64'hFFFF_FFFF_FFFF_FFFF), .no_gap(1));
            end
        join
        wait_drained();
        while (rules_held > 0) begin
            for (int s = 0; s < CAP; s++)
                if (tbl_used[s]) begin
                    send_req(pmrm_pkg::KIND_DEL, .tid(tbl_rid[s]));
                    break;
                end
        end
        wait_drained();
    endtask

    // Cycles the id counter past its wrap so that duplicate ids coexist.
    task automatic test_id_wrap();
        send_req(pmrm_pkg::KIND_ADD, .rtype(0), .pr(3));
        while (last_id != 8'd255) begin
            send_req(pmrm_pkg::KIND_ADD, .rtype(0), .pr(4), .no_gap(1));
            send_req(pmrm_pkg::KIND_DEL, .tid(last_id), .no_gap(1));
        end
        send_req(pmrm_pkg::KIND_ADD, .rtype(0), .ou(64'h10), .pr(5));
        send_req(pmrm_pkg::KIND_ADD, .rtype(0), .pr(2));
        send_req(pmrm_pkg::KIND_DEL, .tid(8'd1));
        send_req(pmrm_pkg::KIND_MATCH, .m(64'h0));
        wait_drained();
    endtask

    task automatic test_random(int count);
        int r;
        logic [7:0] tid;
        logic [63:0] a, b;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                a = sparse64();
                b = sparse64();
                send_req(pmrm_pkg::KIND_ADD,
                         .rtype(($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                                            : 2'($urandom_range(0, 1))),
                         .iu(($urandom_range(0, 9) == 0) ? rnd64() : (a & ~b)),
                         .idn(($urandom_range(0, 9) == 0) ? rnd64() : (b & ~a)),
                         .ou(($urandom_range(0, 3) == 0) ? rnd64() : sparse64()),
                         .od(sparse64() & sparse64()), .pr(4'($urandom_range(0, 15))));
            end else if (r < 58) begin
                tid = 8'($urandom());
                if (rules_held > 0 && $urandom_range(0, 3) != 0) begin
                    do tid = 8'($urandom_range(0, CAP - 1)); while (!tbl_used[tid]);
                    tid = tbl_rid[tid];
                end
                send_req(pmrm_pkg::KIND_DEL, .tid(tid));
            end else if (r < 96) begin
                a = rnd64();
                if (rules_held > 0 && $urandom_range(0, 1) == 0) begin
                    int s;
                    do s = $urandom_range(0, CAP - 1); while (!tbl_used[s]);
                    a = (a | tbl_iu[s]) & ~tbl_id[s];
                end
                send_req(pmrm_pkg::KIND_MATCH, .m(a));
            end else begin
                send_req(pmrm_pkg::KIND_NOP, .rtype(2'($urandom())), .tid(8'($urandom())),
                         .m(rnd64()));
            end
        end
        wait_drained();
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.kind = pmrm_pkg::KIND_NOP; req_ch.rule_type = '0;
        req_ch.in_up_mask = '0; req_ch.in_down_mask = '0;
        req_ch.out_up_mask = '0; req_ch.out_down_mask = '0;
        req_ch.prio_level = '0; req_ch.target_id = '0; req_ch.match_mask = '0;
        for (int s = 0; s < CAP; s++) tbl_used[s] = 0;
        rules_held = 0;
        last_id = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_add_checks();
        test_full_and_stall();
        test_random(20);
        test_id_wrap();
        test_random(20);

        repeat (80) @(posedge i_clk);
        $display("Covered %0d requests and %0d result beats (%0d rule hits),", n_req, n_rsp,
                 n_hits);
        $display("with full table, id wrap, all error codes and a long response stall.");
        if (errors == 0 && expected_beats.size() == 0) begin
            $display("prioritized_mask_rule_matcher: match");
        end else begin
            $display("prioritized_mask_rule_matcher: mismatch");
        end
        $finish;
    end
endmodule
